FILE: design/strict_radix_string_to_u64_defines.svh
// Assertion macros shared by the parser RTL.
`ifndef STRICT_RADIX_STRING_TO_U64_DEFINES_SVH
`define STRICT_RADIX_STRING_TO_U64_DEFINES_SVH

`ifndef SYNTHESIS
`define STRTU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STRTU_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define STRTU_ASSERT(label, clk, rst_n, prop, msg)
`define STRTU_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif

`endif

FILE: design/strtu_pkg.sv
// Types, constants and digit decode shared by the radix parser.
package strtu_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [5:0] MAX_RADIX   = 6'd36;
    localparam logic [5:0] RESET_RADIX = 6'd10;
    localparam logic [5:0] RADIX_OCT   = 6'd8;
    localparam logic [5:0] RADIX_DEC   = 6'd10;
    localparam logic [5:0] RADIX_HEX   = 6'd16;

    localparam logic [63:0] U64_MAX_VAL = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] U32_MAX_VAL = 64'h0000_0000_FFFF_FFFF;

    localparam logic [REG_IDX_BITS-1:0] REG_RADIX = 1'b0;
    localparam logic [REG_IDX_BITS-1:0] REG_LIMIT = 1'b1;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_7  = 8'h37;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5a;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7a;
    localparam logic [7:0] CH_X  = 8'h78;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RANGE     = 2'd1,
        STATUS_BAD_RADIX = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        LA_NONE,
        LA_ZERO,
        LA_ZERO_X
    } lookahead_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_marker;
    } in_beat_t;

    typedef struct packed {
        logic [63:0]           value;
        status_t               status;
        logic [COUNT_BITS-1:0] consumed_count;
    } out_beat_t;

    typedef struct packed {
        logic [5:0] radix;
        logic       limit_32;
    } cfg_t;

    typedef struct packed {
        logic [63:0]           acc;
        logic                  ovf;
        logic                  stop;
        logic [COUNT_BITS-1:0] cnt;
    } parse_state_t;

    // bit 6: character is alphanumeric; bits 5:0: its digit value
    function automatic logic [6:0] char_digit(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[CH_0:CH_9]}) begin
            r = {1'b1, 6'(c - CH_0)};
        end else if (c inside {[CH_LA:CH_LZ]}) begin
            r = {1'b1, 6'(c - CH_LA) + 6'd10};
        end else if (c inside {[CH_UA:CH_UZ]}) begin
            r = {1'b1, 6'(c - CH_UA) + 6'd10};
        end
        return r;
    endfunction

endpackage

FILE: design/strtu_apb_regs.sv
// APB register file holding the radix and 32-bit limit settings.
module strtu_apb_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [strtu_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output strtu_pkg::cfg_t                   cfg
);
    import strtu_pkg::*;

    logic [5:0]              radix_reg;
    logic                    limit_reg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RESET_RADIX;
            limit_reg <= 1'b0;
        end else if (wr_en) begin
            if (reg_idx == REG_RADIX) begin
                radix_reg <= pwdata[5:0];
            end else begin
                limit_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_RADIX) begin
            prdata = {26'd0, radix_reg};
        end else begin
            prdata = {31'd0, limit_reg};
        end
    end

    assign cfg.radix    = radix_reg;
    assign cfg.limit_32 = limit_reg;

endmodule

FILE: design/strtu_digit_feed.sv
// One digit step: validate, count, multiply-accumulate and detect overflow.
module strtu_digit_feed (
    input  logic [5:0]             base,
    input  logic [7:0]             char_code,
    input  strtu_pkg::parse_state_t st_in,
    output strtu_pkg::parse_state_t st_out
);
    import strtu_pkg::*;

    logic [6:0]  dig;
    logic        dig_ok;
    logic [69:0] prod;

    assign dig    = char_digit(char_code);
    assign dig_ok = dig[6] && (dig[5:0] < base);
    assign prod   = 70'(st_in.acc) * 70'(base) + 70'(dig[5:0]);

    always_comb begin
        st_out = st_in;
        if (!st_in.stop) begin
            if (!dig_ok) begin
                st_out.stop = 1'b1;
            end else begin
                if (st_in.cnt != {COUNT_BITS{1'b1}}) begin
                    st_out.cnt = st_in.cnt + COUNT_BITS'(1);
                end
                if (!st_in.ovf) begin
                    if (prod[69:64] != 6'd0) begin
                        st_out.ovf = 1'b1;
                    end else begin
                        st_out.acc = prod[63:0];
                    end
                end
            end
        end
    end

endmodule

FILE: design/strict_radix_string_to_u64.sv
// Top level: input register, parse state, one digit step, result register.
// Throughput: one beat per cycle on the input, sustained, but an end-marker beat is held while the result is not taken.
// The end-marker beat passes the input register; its result is then registered and shown on m_valid.
// The path per cycle is one 64x6 multiply-add with overflow check in strtu_digit_feed.
// Reset (aresetn low, synchronous) clears the parse state and both beat valid flags,
// sets radix to 10 and limit_32 to 0.
`include "strict_radix_string_to_u64_defines.svh"

module strict_radix_string_to_u64 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  strtu_pkg::in_beat_t               s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output strtu_pkg::out_beat_t              m_payload,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [strtu_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import strtu_pkg::*;

    cfg_t         cfg;
    logic         in_valid_reg;
    in_beat_t     in_data_reg;
    logic         out_valid_reg;
    out_beat_t    out_data_reg;
    parse_state_t state_reg, state_next;
    logic [5:0]   act_reg, act_next;
    lookahead_t   fill_reg, fill_next;

    logic         out_free;
    logic         proc_fire;
    logic [5:0]   feed_base;
    logic         feed_en;
    parse_state_t feed_in, feed_out;
    parse_state_t end_st;
    logic [5:0]   end_base;
    out_beat_t    result;
    logic [6:0]   cur_dig;
    logic [7:0]   c;

    strtu_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    strtu_digit_feed u_feed (
        .base      (feed_base),
        .char_code (in_data_reg.char_code),
        .st_in     (feed_in),
        .st_out    (feed_out)
    );

    assign out_free  = !out_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && (!in_data_reg.end_marker || out_free);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign c         = in_data_reg.char_code;
    assign cur_dig   = char_digit(c);

    always_comb begin
        feed_base = act_reg;
        feed_in   = state_reg;
        feed_en   = 1'b0;
        act_next  = act_reg;
        fill_next = fill_reg;
        if (act_reg != 6'd0) begin
            feed_en = (act_reg <= MAX_RADIX);
        end else begin
            case (fill_reg)
                LA_NONE: begin
                    if (cfg.radix != 6'd0) begin
                        act_next  = cfg.radix;
                        feed_base = cfg.radix;
                        feed_en   = (cfg.radix <= MAX_RADIX);
                    end else if (c == CH_0) begin
                        fill_next = LA_ZERO;
                    end else begin
                        act_next  = RADIX_DEC;
                        feed_base = RADIX_DEC;
                        feed_en   = 1'b1;
                    end
                end
                LA_ZERO: begin
                    fill_next = LA_NONE;
                    if (c inside {[CH_0:CH_7]}) begin
                        act_next  = RADIX_OCT;
                        feed_base = RADIX_OCT;
                        feed_in.cnt = COUNT_BITS'(1);
                        feed_en   = 1'b1;
                    end else if (c == CH_X) begin
                        fill_next = LA_ZERO_X;
                    end else begin
                        act_next  = RADIX_DEC;
                        feed_base = RADIX_DEC;
                        feed_in.cnt = COUNT_BITS'(1);
                        feed_en   = 1'b1;
                    end
                end
                LA_ZERO_X: begin
                    fill_next = LA_NONE;
                    if (cur_dig[6] && (cur_dig[5:0] < RADIX_HEX)) begin
                        act_next  = RADIX_HEX;
                        feed_base = RADIX_HEX;
                        feed_in.cnt = COUNT_BITS'(2);
                        feed_en   = 1'b1;
                    end else begin
                        act_next     = RADIX_DEC;
                        feed_in.cnt  = COUNT_BITS'(1);
                        feed_in.stop = 1'b1;
                    end
                end
                default: begin
                    fill_next = LA_NONE;
                end
            endcase
        end
    end

    assign state_next = feed_en ? feed_out : feed_in;

    always_comb begin
        end_st   = state_reg;
        end_base = act_reg;
        if (act_reg == 6'd0) begin
            if (fill_reg == LA_NONE && cfg.radix != 6'd0) begin
                end_base = cfg.radix;
            end else begin
                end_base   = RADIX_DEC;
                end_st.cnt = (fill_reg != LA_NONE) ? COUNT_BITS'(1) : '0;
            end
        end
        result.consumed_count = end_st.cnt;
        if (end_base > MAX_RADIX) begin
            result.value          = '0;
            result.status         = STATUS_BAD_RADIX;
            result.consumed_count = '0;
        end else if (end_st.ovf) begin
            result.value  = cfg.limit_32 ? U32_MAX_VAL : U64_MAX_VAL;
            result.status = STATUS_RANGE;
        end else if (cfg.limit_32 && end_st.acc > U32_MAX_VAL) begin
            result.value  = U32_MAX_VAL;
            result.status = STATUS_RANGE;
        end else begin
            result.value  = end_st.acc;
            result.status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            act_reg   <= 6'd0;
            fill_reg  <= LA_NONE;
        end else if (proc_fire) begin
            if (in_data_reg.end_marker) begin
                state_reg <= '0;
                act_reg   <= 6'd0;
                fill_reg  <= LA_NONE;
            end else begin
                state_reg <= state_next;
                act_reg   <= act_next;
                fill_reg  <= fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_data_reg.end_marker) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && in_data_reg.end_marker) begin
            out_data_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    `STRTU_ASSERT(a_bad_radix_zero, aclk, aresetn, (out_valid_reg && out_data_reg.status == STATUS_BAD_RADIX) |-> (out_data_reg.value == 64'd0 && out_data_reg.consumed_count == '0), "bad radix result must carry zero value and count")
    `STRTU_ASSERT(a_lookahead_undecided, aclk, aresetn, (fill_reg != LA_NONE) |-> (act_reg == 6'd0), "lookahead pending with radix already decided")
    `STRTU_ASSERT(a_ovf_has_radix, aclk, aresetn, state_reg.ovf |-> (act_reg != 6'd0), "overflow flagged before radix decided")
    `STRTU_ASSERT_NEXT(a_clear_after_end, aclk, aresetn, proc_fire && in_data_reg.end_marker, state_reg == '0 && act_reg == 6'd0 && fill_reg == LA_NONE && out_valid_reg, "parse state not cleared after end beat")

endmodule
